// File: src/pixel_format_to_rgba8_unit_defines.svh
// Assertion macros used by the checker file of the pixel format converter.
`ifndef PIXEL_FORMAT_TO_RGBA8_UNIT_DEFINES_SVH
`define PIXEL_FORMAT_TO_RGBA8_UNIT_DEFINES_SVH

// Checked on every clock edge outside reset.
`define PFR8_ASSERT(lbl, prop) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) prop) \
    else $error("pfr8 assertion failed");

// Checked on every clock edge, reset included.
`define PFR8_ASSERT_ALWAYS(lbl, prop) \
  lbl: assert property (@(posedge clk_i) prop) \
    else $error("pfr8 assertion failed during reset");

`endif

// File: src/pfr8_pkg.sv
// Types and constants shared by the pixel format converter modules.
package pfr8_pkg;

  // Configuration port geometry.
  localparam int unsigned PaddrWidth = 3;
  localparam int unsigned PdataWidth = 32;

  // Register indexes.
  localparam logic RegFormat = 1'b0;

  // Source format codes; code 3 is unassigned and passes through.
  typedef enum logic [1:0] {
    FmtRgba8   = 2'd0,
    FmtBgra8   = 2'd1,
    FmtRgba16f = 2'd2
  } fmt_e;

  // Binary16 field limits and shift constants.
  localparam logic [4:0] HalfExpMax  = 5'h1F;
  localparam logic [4:0] HalfExpOne  = 5'd15;
  localparam logic [4:0] SubnShift   = 5'd24;
  localparam logic [4:0] NormShiftOf = 5'd25;

  // Input item.
  typedef struct packed {
    logic [63:0] pixel_data;
    logic        last_pixel;
  } pix_in_t;

  // Result item.
  typedef struct packed {
    logic [31:0] rgba_out;
    logic        last_out;
  } pix_out_t;

endpackage

// File: src/pfr8_cfg_regs.sv
// Configuration register file with its APB-style access port.
module pfr8_cfg_regs (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  logic                              psel_i,
  input  logic                              penable_i,
  input  logic                              pwrite_i,
  input  logic [pfr8_pkg::PaddrWidth-1:0]   paddr_i,
  input  logic [pfr8_pkg::PdataWidth-1:0]   pwdata_i,
  output logic [pfr8_pkg::PdataWidth-1:0]   prdata_o,
  output logic                              pready_o,
  output logic [1:0]                        format_o
);
  import pfr8_pkg::*;

  logic [1:0] format_d, format_q;
  logic       reg_hit;
  logic       wr_en;

  // Register index comes from the word address.
  assign reg_hit = (paddr_i[PaddrWidth-1] == RegFormat);
  assign wr_en   = psel_i && penable_i && pwrite_i && pready_o;

  // Format register update.
  always_comb begin
    format_d = format_q;
    if (wr_en && reg_hit) begin
      format_d = pwdata_i[1:0];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      format_q <= FmtRgba8;
    end else begin
      format_q <= format_d;
    end
  end

  // Read data; addresses beyond the register read as zero.
  always_comb begin
    prdata_o = '0;
    if (reg_hit) begin
      prdata_o = {{(PdataWidth-2){1'b0}}, format_q};
    end
  end

  assign pready_o = 1'b1;
  assign format_o = format_q;

endmodule

// File: src/pfr8_half_to_unorm8.sv
// Converts one binary16 channel to an unorm8 byte with round to nearest.
module pfr8_half_to_unorm8 (
  input  logic [15:0] half_i,
  output logic [7:0]  byte_o
);
  import pfr8_pkg::*;

  logic        sign;
  logic [4:0]  expo;
  logic [9:0]  mant;
  logic [10:0] sig;
  logic [4:0]  sh;
  logic [18:0] prod;
  logic [24:0] rnd;
  logic [24:0] sum;
  logic [24:0] scaled;

  assign sign = half_i[15];
  assign expo = half_i[14:10];
  assign mant = half_i[9:0];

  // Significand and shift for normal and subnormal inputs.
  assign sig = (expo == 5'd0) ? {1'b0, mant} : {1'b1, mant};
  assign sh  = (expo == 5'd0) ? SubnShift : (NormShiftOf - expo);

  // Scale by 255 and add half an output step before the shift.
  assign prod   = {sig, 8'b0} - {8'b0, sig};
  assign rnd    = 25'd1 << (sh - 5'd1);
  assign sum    = {6'b0, prod} + rnd;
  assign scaled = sum >> sh;

  // Special cases: negative, infinity or NaN, and values of one or more.
  always_comb begin
    if (sign) begin
      byte_o = 8'd0;
    end else if (expo == HalfExpMax) begin
      byte_o = (mant == 10'd0) ? 8'hFF : 8'd0;
    end else if (expo >= HalfExpOne) begin
      byte_o = 8'hFF;
    end else begin
      byte_o = scaled[7:0];
    end
  end

endmodule

// File: src/pfr8_convert.sv
// Format selection: passthrough, red/blue swap, or four half-float channels.
module pfr8_convert (
  input  logic [1:0]  format_i,
  input  logic [63:0] pixel_i,
  output logic [31:0] rgba_o
);
  import pfr8_pkg::*;

  logic [31:0] lo;
  logic [31:0] half_rgba;

  assign lo = pixel_i[31:0];

  // One converter per channel, channel 0 in the low bits.
  for (genvar c = 0; c < 4; c++) begin : g_chan
    pfr8_half_to_unorm8 u_half (
      .half_i (pixel_i[16*c +: 16]),
      .byte_o (half_rgba[8*c +: 8])
    );
  end

  always_comb begin
    case (format_i)
      FmtBgra8:   rgba_o = {lo[31:24], lo[7:0], lo[15:8], lo[23:16]};
      FmtRgba16f: rgba_o = half_rgba;
      default:    rgba_o = lo;
    endcase
  end

endmodule

// File: src/pixel_format_to_rgba8_unit.sv
// Top level of the pixel format converter: register port and two-stage pipeline.
//
// Converts one read-back pixel per item to 8-bit RGBA, R in the lowest byte.
// The input channel (in_valid_i, in_stall_o, in_data_i) carries a 64-bit pixel
// and a last-pixel flag; the result channel (out_valid_o, out_stall_i,
// out_data_o) carries the 32-bit RGBA word and the copied flag. An item is
// taken at a clock edge with valid high and stall low.
// The source format register sits at byte address 0 of the APB-style port:
// 0 RGBA8 passthrough, 1 BGRA8 red/blue swap, 2 RGBA16F to unorm8, 3 acts as 0.
// Write it only while no item is in flight.
// The item is captured in the input register, converted by the channel logic,
// and captured in the result register. Throughput is one item per cycle while
// the receiver does not stall. While it stalls, the result register holds its
// item and the input register can still take one more; in_stall_o rises only
// when both are full. Reset empties both stages and sets the format to RGBA8.
module pixel_format_to_rgba8_unit (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  logic                              psel,
  input  logic                              penable,
  input  logic                              pwrite,
  input  logic [pfr8_pkg::PaddrWidth-1:0]   paddr,
  input  logic [pfr8_pkg::PdataWidth-1:0]   pwdata,
  output logic [pfr8_pkg::PdataWidth-1:0]   prdata,
  output logic                              pready,
  input  logic                              in_valid_i,
  output logic                              in_stall_o,
  input  pfr8_pkg::pix_in_t                 in_data_i,
  output logic                              out_valid_o,
  input  logic                              out_stall_i,
  output pfr8_pkg::pix_out_t                out_data_o
);
  import pfr8_pkg::*;

  logic [1:0]  format;
  logic        in_vld_d, in_vld_q;
  pix_in_t     in_q;
  logic        out_vld_d, out_vld_q;
  pix_out_t    out_d, out_q;
  logic        out_free;
  logic        in_free;
  logic [31:0] rgba;

  pfr8_cfg_regs u_cfg (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .psel_i    (psel),
    .penable_i (penable),
    .pwrite_i  (pwrite),
    .paddr_i   (paddr),
    .pwdata_i  (pwdata),
    .prdata_o  (prdata),
    .pready_o  (pready),
    .format_o  (format)
  );

  pfr8_convert u_conv (
    .format_i (format),
    .pixel_i  (in_q.pixel_data),
    .rgba_o   (rgba)
  );

  // Stage flow: the result stage frees up when empty or taken this cycle.
  assign out_free   = !out_vld_q || !out_stall_i;
  assign in_free    = !in_vld_q || out_free;
  assign in_stall_o = !in_free;

  assign in_vld_d  = in_free ? in_valid_i : in_vld_q;
  assign out_vld_d = out_free ? in_vld_q : out_vld_q;

  always_comb begin
    out_d.rgba_out = rgba;
    out_d.last_out = in_q.last_pixel;
  end

  // Valid flags.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_vld_q  <= 1'b0;
      out_vld_q <= 1'b0;
    end else begin
      in_vld_q  <= in_vld_d;
      out_vld_q <= out_vld_d;
    end
  end

  // Payload registers.
  always_ff @(posedge clk_i) begin
    if (in_free && in_valid_i) begin
      in_q <= in_data_i;
    end
    if (out_free && in_vld_q) begin
      out_q <= out_d;
    end
  end

  assign out_valid_o = out_vld_q;
  assign out_data_o  = out_q;

endmodule

// File: src/pfr8_checker.sv
// Port-level checks of the pixel format converter and their bind.
`include "pixel_format_to_rgba8_unit_defines.svh"

module pfr8_checker (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  logic                              in_valid_i,
  input  logic                              in_stall_o,
  input  pfr8_pkg::pix_in_t                 in_data_i,
  input  logic                              out_valid_o,
  input  logic                              out_stall_i,
  input  pfr8_pkg::pix_out_t                out_data_o
);
  import pfr8_pkg::*;

  logic in_take;
  logic out_free;
  logic last_in;
  logic last_out;

  assign in_take  = in_valid_i && !in_stall_o;
  assign out_free = !out_valid_o || !out_stall_i;
  assign last_in  = in_data_i.last_pixel;
  assign last_out = out_data_o.last_out;

  // A stalled result holds its value.
  `PFR8_ASSERT(a_out_hold, out_valid_o && out_stall_i |=> out_valid_o && $stable(out_data_o))

  // The input side backs up only behind a stalled result.
  `PFR8_ASSERT(a_stall_cause, in_stall_o |-> out_valid_o && out_stall_i)

  // An accepted item passes through the input register and shows up on the output when the result stage can move.
  `PFR8_ASSERT(a_latency, in_take ##1 out_free |=> out_valid_o && (last_out == $past(last_in, 2)))

  // Reset leaves no result on the output.
  `PFR8_ASSERT_ALWAYS(a_reset_empty, !rst_ni |=> !out_valid_o)

endmodule

bind pixel_format_to_rgba8_unit pfr8_checker u_checker (.*);
